@@ rtl/core/size_budget_batch_selector_core_defines.svh @@
`ifndef SIZE_BUDGET_BATCH_SELECTOR_CORE_DEFINES_SVH
`define SIZE_BUDGET_BATCH_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBBS_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sbbs assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SBBS_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sbbs assertion failed");

`endif

@@ rtl/core/sbbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sbbs_pkg;

    localparam int SIZE_W = 40;
    localparam int SUM_W  = 46;
    localparam int NF_W   = 6;
    localparam int FIDX_W = 5;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_NEXT     = 2'd1;
    localparam logic [1:0] ACT_COMPLETE = 2'd2;

    localparam logic CFG_BUDGET    = 1'b0;
    localparam logic CFG_NUM_FILES = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [FIDX_W-1:0] entry_idx;
        logic [SIZE_W-1:0] entry_size;
        logic              wanted;
    } sbbs_in_t;

    typedef struct packed {
        logic [FIDX_W-1:0] selected_index;
        logic              selected_valid;
        logic              last;
        logic              all_done;
    } sbbs_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_WALK,
        ST_FINISH
    } sbbs_state_t;

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0]  a,
        input logic [SIZE_W-1:0] b
    );
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - SIZE_W){1'b0}}, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/size_budget_batch_selector_core.sv @@
// channel   dir  handshake             payload
// req       in   req_valid/req_stall   req_data  (action, entry_idx, entry_size, wanted)
// rsp       out  rsp_valid/rsp_stall   rsp_data  (selected_index, selected_valid, last, all_done)
// apb       in   psel/penable/pready   paddr, pwdata, prdata (budget at 0x0, num_files at 0x8)
//
// load, complete and unused actions: the transaction moves to the finish state, whose result is
//   registered once the output register is free; the next transaction is taken back in idle
// next batch: a sum pass then an admit walk over the n entries in use, then finish; one size
//   memory read port and one saturating adder/comparator visit one entry per cycle, except while
//   the admit walk is held, once to sum and once to admit
// req_stall stays high from acceptance until the final result enters the output register
// the admit walk pauses while an admitted result waits on a stalled output register
// reset clears flags, config and control; the size memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "size_budget_batch_selector_core_defines.svh"

module size_budget_batch_selector_core
    import sbbs_pkg::*;
#(
    parameter int MAX_FILES = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output      logic        req_stall,
    input  wire sbbs_in_t    req_data,
    output      logic        rsp_valid,
    input  wire logic        rsp_stall,
    output      sbbs_out_t   rsp_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output      logic [63:0] prdata,
    output      logic        pready
);

    localparam int IW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int CW = $clog2(MAX_FILES + 1);
    localparam logic [6:0] MAXF = 7'(MAX_FILES);

    // config registers
    logic [SUM_W-1:0] budget_reg;
    logic [NF_W-1:0]  num_files_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= SUM_MAX;
            num_files_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3])
                CFG_BUDGET:    budget_reg    <= pwdata[SUM_W-1:0];
                CFG_NUM_FILES: num_files_reg <= pwdata[NF_W-1:0];
                default:       budget_reg    <= budget_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            CFG_BUDGET:    prdata = 64'(budget_reg);
            CFG_NUM_FILES: prdata = 64'(num_files_reg);
            default:       prdata = '0;
        endcase
    end

    // control and flag state
    sbbs_state_t          state_reg, state_next;
    logic [MAX_FILES-1:0] wanted_reg, wanted_next;
    logic [MAX_FILES-1:0] busy_reg, busy_next;
    logic [MAX_FILES-1:0] done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 rvalid_reg, rvalid_next;
    logic [IW-1:0]        ridx_reg, ridx_next;
    logic [SUM_W-1:0]     total_reg, total_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 first_valid_reg, first_valid_next;
    logic [IW-1:0]        first_idx_reg, first_idx_next;
    logic                 out_valid_reg, out_valid_next;
    sbbs_out_t            out_data_reg, out_data_next;

    logic [CW-1:0]        n_use;
    logic [MAX_FILES-1:0] open_vec;
    logic                 all_done;
    logic                 idx_ok;
    logic [IW-1:0]        wr_addr;
    logic                 mem_wr_en;
    logic                 rd_en;
    logic [SIZE_W-1:0]    rdata;
    logic [SUM_W-1:0]     cand;
    logic                 ent_w, ent_b, ent_d;
    logic                 fits;
    logic                 admit;
    logic                 issue_ok;
    logic                 scan_end;
    logic                 out_free;
    logic                 hold;
    logic                 out_push;

    always_comb
    begin
        if ({1'b0, num_files_reg} >= MAXF)
        begin
            n_use = CW'(MAX_FILES);
        end
        else
        begin
            n_use = CW'(num_files_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_FILES; i++)
        begin
            open_vec[i] = wanted_reg[i] & ~done_reg[i] & (CW'(i) < n_use);
        end
        all_done = ~|open_vec;
    end

    assign idx_ok  = {2'b00, req_data.entry_idx} < MAXF;
    assign wr_addr = IW'(req_data.entry_idx);

    sbbs_size_mem #(
        .DEPTH (MAX_FILES),
        .AW    (IW)
    ) u_size_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (req_data.entry_size),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (rdata)
    );

    // shared saturating adder and budget compare
    assign cand     = sat_add(total_reg, rdata);
    assign fits     = cand <= budget_reg;
    assign ent_w    = wanted_reg[ridx_reg];
    assign ent_b    = busy_reg[ridx_reg];
    assign ent_d    = done_reg[ridx_reg];
    assign admit    = (state_reg == ST_WALK) && rvalid_reg && ent_w && !ent_d && !ent_b && fits;
    assign out_free = !out_valid_reg || !rsp_stall;
    assign hold     = admit && pend_valid_reg && !out_free;
    assign issue_ok = cnt_reg < n_use;
    assign scan_end = !issue_ok && !rvalid_reg;
    assign rd_en    = ((state_reg == ST_SUM) || (state_reg == ST_WALK)) && !hold && issue_ok;

    always_comb
    begin
        state_next       = state_reg;
        wanted_next      = wanted_reg;
        busy_next        = busy_reg;
        done_next        = done_reg;
        cnt_next         = cnt_reg;
        rvalid_next      = rvalid_reg;
        ridx_next        = ridx_reg;
        total_next       = total_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        first_valid_next = first_valid_reg;
        first_idx_next   = first_idx_reg;
        out_data_next    = out_data_reg;
        out_push         = 1'b0;
        mem_wr_en        = 1'b0;
        req_stall        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    pend_valid_next  = 1'b0;
                    first_valid_next = 1'b0;
                    total_next       = '0;
                    cnt_next         = '0;
                    rvalid_next      = 1'b0;
                    state_next       = ST_FINISH;
                    priority if (req_data.action == ACT_LOAD)
                    begin
                        if (idx_ok)
                        begin
                            mem_wr_en            = 1'b1;
                            wanted_next[wr_addr] = req_data.wanted;
                        end
                    end
                    else if (req_data.action == ACT_COMPLETE)
                    begin
                        if (idx_ok)
                        begin
                            busy_next[wr_addr] = 1'b0;
                            done_next[wr_addr] = 1'b1;
                        end
                    end
                    else if (req_data.action == ACT_NEXT)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        // unused action: status result only
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SUM, ST_WALK:
            begin
                if (!hold)
                begin
                    if (issue_ok)
                    begin
                        cnt_next    = cnt_reg + 1'b1;
                        rvalid_next = 1'b1;
                        ridx_next   = cnt_reg[IW-1:0];
                    end
                    else
                    begin
                        rvalid_next = 1'b0;
                    end
                    if (rvalid_reg)
                    begin
                        if (state_reg == ST_SUM)
                        begin
                            if (ent_w && !ent_d && ent_b)
                            begin
                                total_next = cand;
                            end
                        end
                        else if (ent_w && !ent_d && !ent_b)
                        begin
                            if (!first_valid_reg)
                            begin
                                first_valid_next = 1'b1;
                                first_idx_next   = ridx_reg;
                            end
                            if (fits)
                            begin
                                busy_next[ridx_reg] = 1'b1;
                                total_next          = cand;
                                pend_valid_next     = 1'b1;
                                pend_idx_next       = ridx_reg;
                                if (pend_valid_reg)
                                begin
                                    out_push      = 1'b1;
                                    out_data_next = '{
                                        selected_index: FIDX_W'(pend_idx_reg),
                                        selected_valid: 1'b1,
                                        last:           1'b0,
                                        all_done:       all_done
                                    };
                                end
                            end
                        end
                    end
                    if (scan_end)
                    begin
                        if (state_reg == ST_SUM)
                        begin
                            cnt_next   = '0;
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                    priority if (pend_valid_reg)
                    begin
                        out_data_next = '{
                            selected_index: FIDX_W'(pend_idx_reg),
                            selected_valid: 1'b1,
                            last:           1'b1,
                            all_done:       all_done
                        };
                    end
                    else if ((total_reg == '0) && first_valid_reg)
                    begin
                        // nothing fit on an empty batch: force the first candidate in
                        busy_next[first_idx_reg] = 1'b1;
                        out_data_next = '{
                            selected_index: FIDX_W'(first_idx_reg),
                            selected_valid: 1'b1,
                            last:           1'b1,
                            all_done:       all_done
                        };
                    end
                    else
                    begin
                        out_data_next = '{
                            selected_index: '0,
                            selected_valid: 1'b0,
                            last:           1'b1,
                            all_done:       all_done
                        };
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_push || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wanted_reg      <= '0;
            busy_reg        <= '0;
            done_reg        <= '0;
            cnt_reg         <= '0;
            rvalid_reg      <= 1'b0;
            pend_valid_reg  <= 1'b0;
            first_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wanted_reg      <= wanted_next;
            busy_reg        <= busy_next;
            done_reg        <= done_next;
            cnt_reg         <= cnt_next;
            rvalid_reg      <= rvalid_next;
            pend_valid_reg  <= pend_valid_next;
            first_valid_reg <= first_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg      <= ridx_next;
        total_reg     <= total_next;
        pend_idx_reg  <= pend_idx_next;
        first_idx_reg <= first_idx_next;
        out_data_reg  <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // an entry is never both in progress and completed
    `SBBS_ASSERT_NOW(a_busy_done_excl, 1'b1, ((busy_reg & done_reg) == '0))
    // a held admission always names an entry in use while a batch runs
    `SBBS_ASSERT_NOW(a_pend_in_range, (pend_valid_reg && (state_reg != ST_IDLE)), (CW'(pend_idx_reg) < n_use))
    // the sum pass never produces a result
    `SBBS_ASSERT_NOW(a_sum_silent, (state_reg == ST_SUM), !out_push)
    // once the output is free, the final result leaves finish for idle in the next cycle
    `SBBS_ASSERT_NEXT(a_finish_exit, ((state_reg == ST_FINISH) && out_free), (state_reg == ST_IDLE))

endmodule

`default_nettype wire

@@ rtl/core/sbbs_size_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbbs_size_mem
    import sbbs_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [SIZE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output      logic [SIZE_W-1:0] rd_data
);

    logic [SIZE_W-1:0] mem [DEPTH];
    logic [SIZE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
